/* rtl/psg_pkg.sv */
// ----------------------------------------------------------------------------
// psg_pkg
// shared types, codes and the volume table of the tone/noise generator
// ----------------------------------------------------------------------------
`default_nettype none

package psg_pkg;

    localparam int TONE_W   = 10;
    localparam int PERIOD_W = 12;
    localparam int VOL_W    = 14;
    localparam int SHIFT_W  = 17;
    localparam int SUM_W    = 17;
    localparam int SAMPLE_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_STEREO = 2'd2
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FREQ_LIMIT  = 3'd0,
        CFG_TAP_FIRST   = 3'd1,
        CFG_TAP_SECOND  = 3'd2,
        CFG_SHIFT_WIDTH = 3'd3,
        CFG_ZERO_MAX    = 3'd4,
        CFG_CH_ENABLE   = 3'd5
    } cfg_index_t;

    localparam logic [2:0] ADDR_TONE0 = 3'd0;
    localparam logic [2:0] ADDR_VOL0  = 3'd1;
    localparam logic [2:0] ADDR_TONE1 = 3'd2;
    localparam logic [2:0] ADDR_VOL1  = 3'd3;
    localparam logic [2:0] ADDR_TONE2 = 3'd4;
    localparam logic [2:0] ADDR_VOL2  = 3'd5;
    localparam logic [2:0] ADDR_NOISE = 3'd6;
    localparam logic [2:0] ADDR_VOL3  = 3'd7;

    localparam logic [3:0]          VOL_OFF       = 4'hF;
    localparam logic [PERIOD_W-1:0] PERIOD_ZERO_MAX = 12'h400;
    localparam logic [PERIOD_W-1:0] NOISE_BASE    = 12'd32;
    localparam logic [SHIFT_W-1:0]  SHIFT_RESET   = 17'h10000;
    localparam logic [1:0]          NOISE_SLAVED  = 2'd3;

    typedef struct packed {
        logic [3:0]                level;
        logic [3:0][PERIOD_W-1:0]  period;
        logic [3:0][3:0]           vol_code;
        logic [3:0]                enable;
        logic [7:0]                mask;
        logic [9:0]                freq_limit;
    } mix_in_t;

    // 2 dB attenuation steps, code 15 is silence
    function automatic logic [VOL_W-1:0] vol_level(input logic [3:0] code);
        logic [VOL_W-1:0] v;
        case (code)
            4'd0:    v = 14'd8192;
            4'd1:    v = 14'd6507;
            4'd2:    v = 14'd5169;
            4'd3:    v = 14'd4106;
            4'd4:    v = 14'd3261;
            4'd5:    v = 14'd2591;
            4'd6:    v = 14'd2058;
            4'd7:    v = 14'd1635;
            4'd8:    v = 14'd1298;
            4'd9:    v = 14'd1031;
            4'd10:   v = 14'd819;
            4'd11:   v = 14'd651;
            4'd12:   v = 14'd517;
            4'd13:   v = 14'd411;
            4'd14:   v = 14'd326;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* rtl/psg_tone_noise_generator.sv */
// ----------------------------------------------------------------------------
// psg_tone_noise_generator
// three square-tone channels and one LFSR noise channel with stereo output
// ----------------------------------------------------------------------------
// Input items: a tick advances the channel counters and
// the noise shift register and its stereo sample lands in the output register
// at the same edge, while register byte writes and stereo mask writes update
// state and give no sample. A new item is taken every cycle as long as the
// output register is empty or its sample is being taken in that cycle, so the
// sustained rate is one item per clock, set by the single output register.
// Configuration writes are taken in any cycle and act at once.
// ----------------------------------------------------------------------------
`default_nettype none

module psg_tone_noise_generator (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    in_valid,
    output logic                                         in_ready,
    input  wire logic [1:0]                              action,
    input  wire logic [7:0]                              data_byte,
    output logic                                         out_valid,
    input  wire logic                                    out_ready,
    output logic signed [psg_pkg::SAMPLE_W-1:0]          left_sample,
    output logic signed [psg_pkg::SAMPLE_W-1:0]          right_sample,
    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic [psg_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  wire logic [psg_pkg::CFG_DATA_W-1:0]          cfg_data
);
    import psg_pkg::*;

    // configuration
    logic [9:0] freq_limit_reg;
    logic [3:0] tap_first_reg;
    logic [3:0] tap_second_reg;
    logic [4:0] shift_width_reg;
    logic       zero_max_reg;
    logic [3:0] ch_enable_reg;

    // generator state
    logic [2:0][TONE_W-1:0]   tone_reg,        tone_next;
    logic [3:0][PERIOD_W-1:0] period_reg,      period_next;
    logic [3:0][PERIOD_W-1:0] count_reg,       count_next;
    logic [3:0]               level_reg,       level_next;
    logic [3:0][3:0]          vol_reg,         vol_next;
    logic [SHIFT_W-1:0]       noise_shift_reg, noise_shift_next;
    logic [2:0]               noise_mode_reg,  noise_mode_next;
    logic [2:0]               latched_reg,     latched_next;
    logic [7:0]               stereo_mask_reg, stereo_mask_next;

    // output register
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] left_reg,      left_next;
    logic signed [SAMPLE_W-1:0] right_reg,     right_next;

    logic                       in_xfer;
    logic                       busy;
    logic [3:0]                 fb_pos;
    logic [SHIFT_W-1:0]         fb_mask;
    logic                       tap_a;
    logic                       tap_c;
    logic [2:0]                 reg_sel;
    logic                       latch;
    logic [1:0]                 tone_idx;
    logic [TONE_W-1:0]          tone_val;
    logic [PERIOD_W-1:0]        tone_period;
    mix_in_t                    mix;
    logic signed [SAMPLE_W-1:0] mix_left;
    logic signed [SAMPLE_W-1:0] mix_right;

    assign in_ready     = !out_valid_reg || out_ready;
    assign in_xfer      = in_valid && in_ready;
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign left_sample  = left_reg;
    assign right_sample = right_reg;

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_limit_reg  <= 10'd2;
            tap_first_reg   <= 4'd0;
            tap_second_reg  <= 4'd3;
            shift_width_reg <= 5'd16;
            zero_max_reg    <= 1'b0;
            ch_enable_reg   <= 4'hF;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FREQ_LIMIT:  freq_limit_reg  <= cfg_data[9:0];
                CFG_TAP_FIRST:   tap_first_reg   <= cfg_data[3:0];
                CFG_TAP_SECOND:  tap_second_reg  <= cfg_data[3:0];
                CFG_SHIFT_WIDTH: shift_width_reg <= cfg_data[4:0];
                CFG_ZERO_MAX:    zero_max_reg    <= cfg_data[0];
                CFG_CH_ENABLE:   ch_enable_reg   <= cfg_data[3:0];
                default:         ;
            endcase
        end
    end

    // feedback position from the clamped shift width
    always_comb
    begin
        if (shift_width_reg == 5'd0)
            fb_pos = 4'd0;
        else if (shift_width_reg > 5'd16)
            fb_pos = 4'd15;
        else
            fb_pos = 4'(shift_width_reg - 5'd1);
        fb_mask = {{(SHIFT_W-1){1'b0}}, 1'b1} << fb_pos;
    end

    always_comb
    begin
        busy = (period_reg[0] != '0) || (period_reg[1] != '0) || (period_reg[2] != '0);
        for (int i = 0; i < 4; i++)
        begin
            if (vol_reg[i] != VOL_OFF)
                busy = 1'b1;
        end
    end

    assign tap_a = noise_shift_reg[tap_first_reg];
    assign tap_c = noise_shift_reg[tap_second_reg] & noise_mode_reg[2];

    // register byte decode
    assign latch    = data_byte[7];
    assign reg_sel  = latch ? data_byte[6:4] : latched_reg;
    assign tone_idx = reg_sel[2:1];
    assign tone_val = latch ? {tone_reg[tone_idx][TONE_W-1:4], data_byte[3:0]}
                            : {data_byte[5:0], tone_reg[tone_idx][3:0]};
    assign tone_period = (tone_val == '0 && zero_max_reg) ? PERIOD_ZERO_MAX
                                                          : {2'b00, tone_val};

    always_comb
    begin
        tone_next        = tone_reg;
        period_next      = period_reg;
        count_next       = count_reg;
        level_next       = level_reg;
        vol_next         = vol_reg;
        noise_shift_next = noise_shift_reg;
        noise_mode_next  = noise_mode_reg;
        latched_next     = latched_reg;
        stereo_mask_next = stereo_mask_reg;

        if (in_xfer)
        begin
            case (action)
                ACT_TICK:
                begin
                    if (busy)
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            if (count_reg[i] <= 12'd1)
                            begin
                                count_next[i] = period_reg[i];
                                if (i < 3)
                                    level_next[i] = ~level_reg[i];
                            end
                            else
                            begin
                                count_next[i] = count_reg[i] - 12'd1;
                            end
                        end
                        if (count_reg[3] <= 12'd1)
                        begin
                            noise_shift_next = (noise_shift_reg >> 1)
                                             | ((tap_a != tap_c) ? fb_mask : '0);
                            level_next[3]    = noise_shift_next[0];
                        end
                    end
                end
                ACT_WRITE:
                begin
                    if (latch)
                        latched_next = data_byte[6:4];
                    unique case (reg_sel) inside
                        ADDR_TONE0, ADDR_TONE1, ADDR_TONE2:
                        begin
                            tone_next[tone_idx]   = tone_val;
                            period_next[tone_idx] = tone_period;
                            if (reg_sel == ADDR_TONE2 && noise_mode_reg[1:0] == NOISE_SLAVED)
                                period_next[3] = {tone_period[PERIOD_W-2:0], 1'b0};
                        end
                        ADDR_VOL0, ADDR_VOL1, ADDR_VOL2, ADDR_VOL3:
                        begin
                            vol_next[reg_sel[2:1]] = data_byte[3:0];
                        end
                        ADDR_NOISE:
                        begin
                            noise_mode_next  = data_byte[2:0];
                            noise_shift_next = fb_mask;
                            if (data_byte[1:0] == NOISE_SLAVED)
                                period_next[3] = {period_reg[2][PERIOD_W-2:0], 1'b0};
                            else
                                period_next[3] = NOISE_BASE << data_byte[1:0];
                        end
                        default: ;
                    endcase
                end
                ACT_STEREO:
                begin
                    stereo_mask_next = data_byte;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        mix.level      = level_next;
        mix.period     = period_reg;
        mix.vol_code   = vol_reg;
        mix.enable     = ch_enable_reg;
        mix.mask       = stereo_mask_reg;
        mix.freq_limit = freq_limit_reg;
    end

    psg_mixer u_mixer (
        .mix        (mix),
        .left_half  (mix_left),
        .right_half (mix_right)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        if (in_xfer && action == ACT_TICK)
        begin
            out_valid_next = 1'b1;
            left_next      = busy ? mix_left  : '0;
            right_next     = busy ? mix_right : '0;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_reg        <= {3{10'd1}};
            period_reg      <= '0;
            count_reg       <= '0;
            level_reg       <= '0;
            vol_reg         <= {4{VOL_OFF}};
            noise_shift_reg <= SHIFT_RESET;
            noise_mode_reg  <= 3'd1;
            latched_reg     <= 3'd0;
            stereo_mask_reg <= 8'hFF;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            tone_reg        <= tone_next;
            period_reg      <= period_next;
            count_reg       <= count_next;
            level_reg       <= level_next;
            vol_reg         <= vol_next;
            noise_shift_reg <= noise_shift_next;
            noise_mode_reg  <= noise_mode_next;
            latched_reg     <= latched_next;
            stereo_mask_reg <= stereo_mask_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // sample payload
    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        right_reg <= right_next;
    end

endmodule

`default_nettype wire

/* rtl/psg_mixer.sv */
// ----------------------------------------------------------------------------
// psg_mixer
// per-channel contribution and stereo sum, halved to a 16-bit sample
// ----------------------------------------------------------------------------
`default_nettype none

module psg_mixer (
    input  psg_pkg::mix_in_t                     mix,
    output logic signed [psg_pkg::SAMPLE_W-1:0]  left_half,
    output logic signed [psg_pkg::SAMPLE_W-1:0]  right_half
);
    import psg_pkg::*;

    logic signed [VOL_W:0] contrib [4];
    logic signed [SUM_W-1:0] l_sum;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] l_shift;
    logic signed [SUM_W-1:0] r_shift;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            logic signed [VOL_W:0] vol;
            logic signed [VOL_W:0] swing;
            vol   = {1'b0, vol_level(mix.vol_code[i])};
            swing = mix.level[i] ? vol : -vol;
            if (!mix.enable[i])
            begin
                contrib[i] = '0;
            end
            else if (i == 3)
            begin
                contrib[i] = swing;
            end
            else if (mix.period[i] > 12'd1)
            begin
                // tones at or below the frequency limit are silenced
                if (mix.period[i] <= {2'b00, mix.freq_limit})
                    contrib[i] = '0;
                else
                    contrib[i] = swing;
            end
            else
            begin
                contrib[i] = vol;
            end
        end
    end

    always_comb
    begin
        l_sum = '0;
        r_sum = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (mix.mask[4+i])
                l_sum = l_sum + {{(SUM_W-VOL_W-1){contrib[i][VOL_W]}}, contrib[i]};
            if (mix.mask[i])
                r_sum = r_sum + {{(SUM_W-VOL_W-1){contrib[i][VOL_W]}}, contrib[i]};
        end
    end

    assign l_shift    = l_sum >>> 1;
    assign r_shift    = r_sum >>> 1;
    assign left_half  = l_shift[SAMPLE_W-1:0];
    assign right_half = r_shift[SAMPLE_W-1:0];

endmodule

`default_nettype wire

/* dv/psg_sample_checker.sv */
// ----------------------------------------------------------------------------
// psg_sample_checker
// watches the item, sample and configuration channels of the tone/noise
// generator, keeps its own model of the generator state, predicts the stereo
// sample of every tick transfer and compares it with each sample transfer
// ----------------------------------------------------------------------------
`default_nettype none

module psg_sample_checker
    import psg_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic                         in_ready,
    input  wire logic [1:0]                   action,
    input  wire logic [7:0]                   data_byte,
    input  wire logic                         out_valid,
    input  wire logic                         out_ready,
    input  wire logic signed [SAMPLE_W-1:0]   left_sample,
    input  wire logic signed [SAMPLE_W-1:0]   right_sample,
    input  wire logic                         cfg_valid,
    input  wire logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        cfg_data,
    output int                                error_count,
    output int                                pending_count,
    output int                                checked_count
);

    typedef struct packed {
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
    } sample_t;

    int atten_level [16] = '{8192, 6507, 5169, 4106, 3261, 2591, 2058, 1635,
                             1298, 1031, 819, 651, 517, 411, 326, 0};

    sample_t expected_q [$];
    sample_t expected_sample;
    sample_t got_sample;

    // configuration copy
    logic [9:0]  cfg_limit;
    logic [3:0]  cfg_tap_a;
    logic [3:0]  cfg_tap_b;
    logic [4:0]  cfg_width;
    logic        cfg_zero_max;
    logic [3:0]  cfg_enable;

    // generator state copy
    logic [TONE_W-1:0]  tone_reg [8];
    logic [2:0]         latch_addr;
    int                 period [4];
    int                 count [4];
    logic [3:0]         level;
    int                 volume [4];
    logic [SHIFT_W-1:0] lfsr;
    logic [7:0]         stereo;

    function automatic logic [SHIFT_W-1:0] feedback_mask();
        int w;
        w = int'(cfg_width);
        if (w < 1) w = 1;
        if (w > 16) w = 16;
        return 17'd1 << (w - 1);
    endfunction

    function automatic void write_register_byte(input logic [7:0] b);
        logic [2:0] addr;
        logic       is_latch;
        logic [1:0] mode;
        int         p;
        is_latch = b[7];
        if (is_latch) begin
            addr = b[6:4];
            latch_addr = addr;
            tone_reg[addr] = {tone_reg[addr][9:4], b[3:0]};
        end else begin
            addr = latch_addr;
        end
        case (addr)
            ADDR_TONE0, ADDR_TONE1, ADDR_TONE2:
            begin
                if (!is_latch)
                    tone_reg[addr] = {b[5:0], tone_reg[addr][3:0]};
                p = int'(tone_reg[addr]);
                if (p == 0 && cfg_zero_max) p = int'(PERIOD_ZERO_MAX);
                period[addr[2:1]] = p;
                if (addr == ADDR_TONE2 && tone_reg[ADDR_NOISE][1:0] == NOISE_SLAVED)
                    period[3] = 2 * period[2];
            end
            ADDR_VOL0, ADDR_VOL1, ADDR_VOL2, ADDR_VOL3:
            begin
                volume[addr[2:1]] = atten_level[b[3:0]];
                if (!is_latch)
                    tone_reg[addr] = {tone_reg[addr][9:4], b[3:0]};
            end
            default:
            begin
                if (!is_latch)
                    tone_reg[ADDR_NOISE] = {tone_reg[ADDR_NOISE][9:4], b[3:0]};
                mode = tone_reg[ADDR_NOISE][1:0];
                period[3] = (mode == NOISE_SLAVED) ? 2 * period[2]
                                                   : int'(NOISE_BASE) << mode;
                lfsr = feedback_mask();
            end
        endcase
    endfunction

    function automatic sample_t next_sample();
        sample_t s;
        int      left_sum;
        int      right_sum;
        int      contrib;
        int      v;
        int      i;
        logic    busy;
        logic    tap_a_bit;
        logic    tap_b_bit;
        left_sum = 0;
        right_sum = 0;
        busy = (volume[3] != 0);
        for (i = 0; i < 3; i++)
            if (period[i] != 0 || volume[i] != 0) busy = 1'b1;
        if (!busy) begin
            s.left = '0;
            s.right = '0;
            return s;
        end
        for (i = 0; i < 3; i++) begin
            count[i]--;
            if (count[i] <= 0) begin
                level[i] = ~level[i];
                count[i] = period[i];
            end
        end
        count[3]--;
        if (count[3] <= 0) begin
            tap_a_bit = lfsr[cfg_tap_a];
            tap_b_bit = tone_reg[ADDR_NOISE][2] ? lfsr[cfg_tap_b] : 1'b0;
            lfsr = lfsr >> 1;
            if (tap_a_bit != tap_b_bit) lfsr = lfsr | feedback_mask();
            level[3] = lfsr[0];
            count[3] = period[3];
        end
        for (i = 0; i < 4; i++) begin
            if (period[i] > 1 || i == 3) begin
                v = level[i] ? 1 : -1;
                if (i != 3 && period[i] <= int'(cfg_limit)) v = 0;
                if (!cfg_enable[i]) v = 0;
                contrib = v * volume[i];
            end else begin
                contrib = cfg_enable[i] ? volume[i] : 0;
            end
            if (stereo[4 + i]) left_sum += contrib;
            if (stereo[i]) right_sum += contrib;
        end
        s.left = 16'(left_sum >>> 1);
        s.right = 16'(right_sum >>> 1);
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_limit = 10'd2;
            cfg_tap_a = 4'd0;
            cfg_tap_b = 4'd3;
            cfg_width = 5'd16;
            cfg_zero_max = 1'b0;
            cfg_enable = 4'hF;
            for (int i = 0; i < 4; i++)
            begin
                tone_reg[2 * i] = 10'd1;
                tone_reg[2 * i + 1] = 10'd15;
                period[i] = 0;
                count[i] = 0;
                volume[i] = 0;
            end
            level = '0;
            latch_addr = '0;
            lfsr = SHIFT_RESET;
            stereo = 8'hFF;
            expected_q.delete();
            error_count = 0;
            pending_count = 0;
            checked_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FREQ_LIMIT:  cfg_limit = cfg_data;
                    CFG_TAP_FIRST:   cfg_tap_a = cfg_data[3:0];
                    CFG_TAP_SECOND:  cfg_tap_b = cfg_data[3:0];
                    CFG_SHIFT_WIDTH: cfg_width = cfg_data[4:0];
                    CFG_ZERO_MAX:    cfg_zero_max = cfg_data[0];
                    CFG_CH_ENABLE:   cfg_enable = cfg_data[3:0];
                    default: ;
                endcase
            end
            // sample transfer is matched before a tick in the same cycle is queued
            if (out_valid && out_ready)
            begin
                got_sample.left = left_sample;
                got_sample.right = right_sample;
                if (expected_q.size() == 0)
                begin
                    error_count++;
                    $display("%0t unexpected sample transfer: left %0d right %0d",
                             $time, left_sample, right_sample);
                end
                else
                begin
                    expected_sample = expected_q.pop_front();
                    checked_count++;
                    if (got_sample.left != expected_sample.left)
                    begin
                        error_count++;
                        $display("%0t left_sample mismatch: expected %0d, got %0d",
                                 $time, $signed(expected_sample.left), left_sample);
                    end
                    if (got_sample.right != expected_sample.right)
                    begin
                        error_count++;
                        $display("%0t right_sample mismatch: expected %0d, got %0d",
                                 $time, $signed(expected_sample.right), right_sample);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                case (action)
                    ACT_TICK:   expected_q.push_back(next_sample());
                    ACT_WRITE:  write_register_byte(data_byte);
                    ACT_STEREO: stereo = data_byte;
                    default: ;
                endcase
            end
            pending_count = expected_q.size();
        end
    end

endmodule

`default_nettype wire

/* dv/psg_tone_noise_generator_tb.sv */
// ----------------------------------------------------------------------------
// psg_tone_noise_generator_tb
// drives register bytes, stereo masks and ticks into the tone/noise generator
// over several configuration settings, with random gaps and stalls on both
// channels; a checker beside the block predicts and compares every sample
// ----------------------------------------------------------------------------
`default_nettype none

module psg_tone_noise_generator_tb;

    import psg_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 250;
    localparam int SETTLE      = 4;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic [1:0]                  action = ACT_TICK;
    logic [7:0]                  data_byte = 8'h00;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0]  left_sample;
    logic signed [SAMPLE_W-1:0]  right_sample;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index = CFG_FREQ_LIMIT;
    logic [CFG_DATA_W-1:0]       cfg_data = '0;

    int error_count;
    int pending_count;
    int checked_count;
    int cycle_count = 0;
    int n_tick = 0;
    int n_write = 0;
    int n_stereo = 0;
    int n_ignored = 0;
    int n_cfg = 0;

    bit tx_idle = 1'b0;
    bit rx_idle = 1'b0;
    bit long_hold = 1'b0;

    logic [2:0] tone_addr [3] = '{ADDR_TONE0, ADDR_TONE1, ADDR_TONE2};
    logic [2:0] vol_addr [4] = '{ADDR_VOL0, ADDR_VOL1, ADDR_VOL2, ADDR_VOL3};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    psg_tone_noise_generator i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    psg_sample_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .left_sample   (left_sample),
        .right_sample  (right_sample),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("run stopped after %0d cycles with %0d samples outstanding",
                     cycle_count, pending_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // sample receiver
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end
            stall = rx_idle ? $urandom_range(0, 19) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_item(input logic [1:0] act, input logic [7:0] value);
        int gap;
        gap = tx_idle ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        data_byte <= value;
        do @(posedge clk); while (!in_ready);
        case (act)
            ACT_TICK:   n_tick++;
            ACT_WRITE:  n_write++;
            ACT_STEREO: n_stereo++;
            default:    n_ignored++;
        endcase
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_count != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_cfg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        n_cfg++;
    endtask

    // latch byte carries the low nibble, data byte the upper six bits
    task automatic tone_pair(input logic [2:0] addr, input logic [9:0] per);
        send_item(ACT_WRITE, {1'b1, addr, per[3:0]});
        send_item(ACT_WRITE, {1'b0, 1'($urandom), per[9:4]});
    endtask

    task automatic random_item();
        int         op;
        int         k;
        logic [9:0] per;
        op = $urandom_range(0, 99);
        if (op < 50)
            send_item(ACT_TICK, 8'($urandom));
        else if (op < 62)
        begin
            k = $urandom_range(0, 2);
            per = ($urandom_range(0, 9) < 7) ? 10'($urandom_range(0, 40)) : 10'($urandom);
            tone_pair(tone_addr[k], per);
        end
        else if (op < 72)
            send_item(ACT_WRITE, {1'b1, vol_addr[$urandom_range(0, 3)], 4'($urandom)});
        else if (op < 76)
            send_item(ACT_WRITE, {1'b1, ADDR_NOISE, 4'($urandom)});
        else if (op < 81)
            send_item(ACT_STEREO, 8'($urandom));
        else if (op < 88)
            send_item(ACT_WRITE, {1'b0, 7'($urandom)});
        else if (op < 93)
            send_item(ACT_WRITE, 8'($urandom));
        else if (op < 96)
            send_item(ACT_UNUSED, 8'($urandom));
        else if (op < 98)
        begin
            // quiet every channel so the generator can go idle
            for (k = 0; k < 3; k++)
                tone_pair(tone_addr[k], 10'd0);
            for (k = 0; k < 4; k++)
                send_item(ACT_WRITE, {1'b1, vol_addr[k], VOL_OFF});
            repeat (3) send_item(ACT_TICK, 8'($urandom));
        end
        else
            wait_drained();
    endtask

    initial
    begin
        logic [9:0] lim;
        logic [3:0] tap_a;
        logic [3:0] tap_b;
        logic [4:0] width;
        logic       zero_max;
        logic [3:0] enable;
        int         start;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed sequence at reset settings
        send_item(ACT_TICK, 8'h00);
        send_item(ACT_UNUSED, 8'hFF);
        send_item(ACT_WRITE, {1'b1, ADDR_TONE0, 4'hF});
        send_item(ACT_WRITE, 8'h3F);
        send_item(ACT_WRITE, {1'b1, ADDR_VOL0, 4'h0});
        send_item(ACT_WRITE, {1'b1, ADDR_TONE1, 4'h1});
        send_item(ACT_WRITE, {1'b1, ADDR_VOL1, 4'h0});
        send_item(ACT_WRITE, {1'b1, ADDR_TONE2, 4'h0});
        send_item(ACT_WRITE, {1'b1, ADDR_VOL2, 4'h0});
        send_item(ACT_WRITE, {1'b1, ADDR_NOISE, 4'h7});
        send_item(ACT_WRITE, {1'b1, ADDR_VOL3, 4'h0});
        repeat (3) send_item(ACT_TICK, 8'hFF);
        send_item(ACT_STEREO, 8'h5A);
        send_item(ACT_WRITE, 8'h4E);
        send_item(ACT_TICK, 8'h00);
        send_item(ACT_WRITE, {1'b1, ADDR_TONE2, 4'h3});
        send_item(ACT_WRITE, 8'h7F);
        send_item(ACT_STEREO, 8'h00);
        send_item(ACT_TICK, 8'h00);
        send_item(ACT_STEREO, 8'hFF);
        repeat (2) send_item(ACT_TICK, 8'h00);
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            tx_idle = (p % 3 != 0);
            rx_idle = (p % 2 != 0);
            case (p)
                0: {lim, tap_a, tap_b, width, zero_max, enable} =
                       {10'd2, 4'd0, 4'd3, 5'd16, 1'b0, 4'hF};
                1: {lim, tap_a, tap_b, width, zero_max, enable} =
                       {10'd0, 4'd15, 4'd0, 5'd1, 1'b1, 4'hF};
                2: {lim, tap_a, tap_b, width, zero_max, enable} =
                       {10'd1023, 4'd0, 4'd15, 5'd31, 1'b0, 4'b1010};
                3: {lim, tap_a, tap_b, width, zero_max, enable} =
                       {10'd1, 4'd1, 4'd2, 5'd0, 1'b1, 4'h0};
                default:
                begin
                    lim = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 30));
                    tap_a = 4'($urandom);
                    tap_b = 4'($urandom);
                    width = 5'($urandom);
                    zero_max = 1'($urandom);
                    enable = ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'hF;
                end
            endcase
            write_cfg(CFG_FREQ_LIMIT, lim);
            write_cfg(CFG_TAP_FIRST, 10'(tap_a));
            write_cfg(CFG_TAP_SECOND, 10'(tap_b));
            write_cfg(CFG_SHIFT_WIDTH, 10'(width));
            write_cfg(CFG_ZERO_MAX, 10'(zero_max));
            write_cfg(CFG_CH_ENABLE, 10'(enable));
            cfg_valid <= 1'b0;
            @(posedge clk);

            // hold off the sample side while ticks keep coming
            if (p == 2) long_hold = 1'b1;

            start = n_tick + n_write + n_stereo;
            while (n_tick + n_write + n_stereo - start < PHASE_ITEMS)
                random_item();
            wait_drained();
        end

        repeat (SETTLE) @(posedge clk);
        $display("stimulus: %0d ticks, %0d register bytes, %0d stereo masks, %0d ignored actions",
                 n_tick, n_write, n_stereo, n_ignored);
        $display("%0d configuration settings (%0d register transfers), %0d samples checked",
                 PHASES, n_cfg, checked_count);
        if (error_count == 0 && pending_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
